// ----- src/pit_pkg.sv -----
// Shared types and constants for the path interning trie.
// Used by every module under src except pit_ram; depends on nothing.
package pit_pkg;

    localparam int NODE_SLOTS_DEF = 1024;
    localparam int EDGE_SLOTS_DEF = 2048;
    localparam int ID_WIDTH_DEF   = 32;
    localparam int MAX_DEPTH_DEF  = 32;

    // guard counter holds up to MAX_DEPTH + 1 for MAX_DEPTH <= 64
    localparam int KW = 7;

    localparam logic [63:0] HASH_K1 = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] HASH_K2 = 64'hC2B2AE3D27D4EB4F;

    localparam logic [2:0] OP_INTERN   = 3'd0;
    localparam logic [2:0] OP_PARENT   = 3'd1;
    localparam logic [2:0] OP_ANCESTOR = 3'd2;
    localparam logic [2:0] OP_HAS      = 3'd3;
    localparam logic [2:0] OP_SHARES   = 3'd4;
    localparam logic [2:0] OP_MAT      = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;
    localparam logic [1:0] ST_DEEP = 2'd3;

    typedef struct packed {
        logic [2:0]  operation;
        logic [9:0]  first_handle;
        logic [9:0]  second_handle;
        logic [31:0] tail_value;
        logic [5:0]  first_depth;
        logic [5:0]  second_depth;
    } t_in_item;

    typedef struct packed {
        logic [9:0]  result_handle;
        logic        flag;
        logic [31:0] out_tail;
        logic [4:0]  position;
        logic        last;
        logic [1:0]  status;
    } t_out_item;

    typedef enum logic [2:0] {
        E_STATUS, E_A, E_PARENT, E_EDGE, E_NEW, E_MAT
    } t_emit;

    typedef enum logic [1:0] {
        RD_A, RD_B, RD_PAR
    } t_nrd;

    typedef struct packed {
        logic       clr_step;
        logic       lat_in;
        logic       nre;
        t_nrd       nrd;
        logic       a_par;
        logic       b_par;
        logic       tgt_d1;
        logic       tgt_d2;
        logic       tgt_rd;
        logic       k_inc;
        logic       hash_start;
        logic       probe_init;
        logic       probe_next;
        logic       erd;
        logic       set_free;
        logic       free_val;
        logic       alloc;
        logic       emit;
        t_emit      emit_sel;
        logic [1:0] st;
        logic       flag;
    } t_cmd;

    typedef struct packed {
        logic       clr_done;
        logic [2:0] op;
        logic       bad1;
        logic       bad2;
        logic       d1_over;
        logic       d1_zero;
        logic       d2_gt_d1;
        logic       depth_gt_tgt;
        logic       a_eq_b;
        logic       a_zero;
        logic       b_zero;
        logic       guard_over;
        logic       hash_done;
        logic       e_valid;
        logic       e_match;
        logic       probe_last;
        logic       deep;
        logic       full;
        logic       have_free;
        logic       out_free;
        logic       mat_last;
    } t_stat;

endpackage

// ----- src/pit_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/pit_hash.sv -----
// Edge hash: multiplicative mix of parent and tail, reduced to a slot index.
// One shared 32x32 multiplier over four steps; depends on pit_pkg.
module pit_hash
    import pit_pkg::*;
#(
    parameter int HW         = 10,
    parameter int EDGE_SLOTS = EDGE_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [HW-1:0]                 i_parent,
    input  logic [31:0]                   i_tail,
    output logic                          o_done,
    output logic [$clog2(EDGE_SLOTS)-1:0] o_slot
);
    localparam int EW = $clog2(EDGE_SLOTS);
    localparam bit POW2 = (EDGE_SLOTS & (EDGE_SLOTS - 1)) == 0;
    // modulo by 16-bit digits: exact quotient per digit from a scaled reciprocal
    localparam int VW = EW + 16;
    localparam int KQ = 2 * EW + 16;
    localparam int RW = EW + 18;
    localparam int PW = VW + RW;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << KQ) + 64'(EDGE_SLOTS) - 64'd1) / 64'(EDGE_SLOTS));

    typedef enum logic [1:0] {H_IDLE, H_MUL, H_MIX, H_MOD} t_hstate;

    t_hstate     r_state;
    logic [2:0]  r_step;
    logic [1:0]  r_dig;
    logic        r_ph;
    logic [15:0] r_q;
    logic        r_done;
    logic [31:0] r_p, r_t;
    logic [63:0] r_prod, r_ap, r_at, r_h;
    logic [EW-1:0] r_rem;

    logic [31:0] opa, opb;
    logic [63:0] hx;
    logic [VW-1:0] v;
    logic [PW-1:0] prod;
    logic [EW-1:0] qm;

    always_comb begin
        opa = r_step[1] ? r_t : r_p;
        case (r_step[1:0])
            2'd0:    opb = HASH_K1[31:0];
            2'd1:    opb = HASH_K1[63:32];
            2'd2:    opb = HASH_K2[31:0];
            default: opb = HASH_K2[63:32];
        endcase
        hx   = r_ap ^ r_at;
        v    = {r_rem, r_h[16*r_dig +: 16]};
        prod = PW'(v) * PW'(RECIP);
        qm   = EW'(r_q) * EW'(EDGE_SLOTS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                H_IDLE: begin
                    if (i_start) begin
                        r_p     <= 32'(i_parent);
                        r_t     <= i_tail;
                        r_step  <= 3'd0;
                        r_state <= H_MUL;
                    end
                end
                H_MUL: begin
                    // product of step n is folded in during step n+1
                    r_prod <= opa * opb;
                    case (r_step)
                        3'd1: r_ap <= r_prod;
                        3'd2: r_ap[63:32] <= r_ap[63:32] + r_prod[31:0];
                        3'd3: r_at <= r_prod;
                        3'd4: r_at[63:32] <= r_at[63:32] + r_prod[31:0];
                        default: ;
                    endcase
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd4) begin
                        r_state <= H_MIX;
                    end
                end
                H_MIX: begin
                    r_h     <= hx ^ (hx >> 29);
                    r_rem   <= '0;
                    r_dig   <= 2'd3;
                    r_ph    <= 1'b0;
                    r_state <= H_MOD;
                end
                H_MOD: begin
                    if (POW2) begin
                        r_rem   <= r_h[EW-1:0];
                        r_done  <= 1'b1;
                        r_state <= H_IDLE;
                    end else if (!r_ph) begin
                        // quotient of the current digit, below 2^16
                        r_q  <= prod[KQ +: 16];
                        r_ph <= 1'b1;
                    end else begin
                        r_rem <= v[EW-1:0] - qm;
                        r_ph  <= 1'b0;
                        r_dig <= r_dig - 2'd1;
                        if (r_dig == 2'd0) begin
                            r_done  <= 1'b1;
                            r_state <= H_IDLE;
                        end
                    end
                end
                default: r_state <= H_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_slot = r_rem;
endmodule

// ----- src/pit_datapath.sv -----
// Datapath: node store, edge table, hash unit, walk registers, output register.
// Depends on pit_pkg, pit_ram and pit_hash.
module pit_datapath
    import pit_pkg::*;
#(
    parameter int NODE_SLOTS = NODE_SLOTS_DEF,
    parameter int EDGE_SLOTS = EDGE_SLOTS_DEF,
    parameter int ID_WIDTH   = ID_WIDTH_DEF,
    parameter int MAX_DEPTH  = MAX_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_in,
    input  logic      i_out_stall,
    output t_stat     o_stat,
    output logic      o_out_valid,
    output t_out_item o_out_data
);
    localparam int HW    = $clog2(NODE_SLOTS);
    localparam int CNW   = $clog2(NODE_SLOTS + 1);
    localparam int EW    = $clog2(EDGE_SLOTS);
    localparam int TW    = (ID_WIDTH < 32) ? ID_WIDTH : 32;
    localparam int DW    = $clog2(MAX_DEPTH + 1);
    localparam int DXW   = ((DW > 6) ? DW : 6) + 1;
    localparam int XW    = (CNW > 10) ? CNW : 10;
    localparam int LIMIT = (MAX_DEPTH < 32) ? MAX_DEPTH : 32;
    localparam int NDW   = HW + TW + DW;
    localparam int EDW   = 1 + HW + TW + HW;

    t_in_item      r_in;
    logic [HW-1:0] r_a, r_b;
    logic [DXW-1:0] r_tgt;
    logic [KW-1:0] r_k;
    logic [CNW-1:0] r_cnt;
    logic [EW-1:0] r_s, r_i, r_clr;
    logic          r_free;
    logic          r_ov;
    t_out_item     r_out;

    logic [TW-1:0] t_val;
    logic [NDW-1:0] nd, n_wdata;
    logic [EDW-1:0] ed, e_wdata;
    logic [HW-1:0] n_par, n_raddr, n_waddr, e_par, e_h;
    logic [TW-1:0] n_tail, e_tail;
    logic [DW-1:0] n_dep;
    logic          e_vld;
    logic [EW-1:0] e_waddr, hash_slot;
    logic          hash_done, out_free;
    t_out_item     n_out;

    assign t_val  = TW'(r_in.tail_value);
    assign n_par  = nd[NDW-1 -: HW];
    assign n_tail = nd[DW +: TW];
    assign n_dep  = nd[DW-1:0];
    assign e_vld  = ed[EDW-1];
    assign e_par  = ed[EDW-2 -: HW];
    assign e_tail = ed[HW +: TW];
    assign e_h    = ed[HW-1:0];
    assign out_free = !r_ov || !i_out_stall;

    always_comb begin
        case (i_cmd.nrd)
            RD_A:    n_raddr = r_a;
            RD_B:    n_raddr = r_b;
            default: n_raddr = n_par;
        endcase
        // the clearing sweep also zeroes the root entry
        n_waddr = i_cmd.clr_step ? '0 : r_cnt[HW-1:0];
        n_wdata = i_cmd.clr_step ? '0 : {r_a, t_val, DW'(n_dep + DW'(1))};
        e_waddr = i_cmd.clr_step ? r_clr : r_s;
        e_wdata = i_cmd.clr_step ? '0 : {1'b1, r_a, t_val, r_cnt[HW-1:0]};
    end

    pit_ram #(.WIDTH(NDW), .DEPTH(NODE_SLOTS)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clr_step | i_cmd.alloc),
        .i_waddr (n_waddr),
        .i_wdata (n_wdata),
        .i_re    (i_cmd.nre),
        .i_raddr (n_raddr),
        .o_rdata (nd)
    );

    pit_ram #(.WIDTH(EDW), .DEPTH(EDGE_SLOTS)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clr_step | i_cmd.alloc),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_re    (i_cmd.erd),
        .i_raddr (r_s),
        .o_rdata (ed)
    );

    pit_hash #(.HW(HW), .EDGE_SLOTS(EDGE_SLOTS)) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.hash_start),
        .i_parent (r_a),
        .i_tail   (32'(t_val)),
        .o_done   (hash_done),
        .o_slot   (hash_slot)
    );

    always_comb begin
        n_out = '0;
        n_out.last = 1'b1;
        n_out.status = ST_OK;
        case (i_cmd.emit_sel)
            E_STATUS: begin
                n_out.flag   = i_cmd.flag;
                n_out.status = i_cmd.st;
            end
            E_A:      n_out.result_handle = 10'(r_a);
            E_PARENT: n_out.result_handle = 10'(n_par);
            E_EDGE:   n_out.result_handle = 10'(e_h);
            E_NEW:    n_out.result_handle = 10'(r_cnt);
            E_MAT: begin
                n_out.result_handle = 10'(r_a);
                n_out.out_tail      = 32'(n_tail);
                n_out.position      = 5'(r_in.first_depth - 6'd1 - 6'(r_k));
                n_out.last          = o_stat.mat_last;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_stat = '0;
        o_stat.clr_done     = r_clr == EW'(EDGE_SLOTS - 1);
        o_stat.op           = r_in.operation;
        o_stat.bad1         = XW'(r_in.first_handle) >= XW'(r_cnt);
        o_stat.bad2         = XW'(r_in.second_handle) >= XW'(r_cnt);
        o_stat.d1_over      = r_in.first_depth > 6'(LIMIT);
        o_stat.d1_zero      = r_in.first_depth == 6'd0;
        o_stat.d2_gt_d1     = r_in.second_depth > r_in.first_depth;
        o_stat.depth_gt_tgt = DXW'(n_dep) > r_tgt;
        o_stat.a_eq_b       = r_a == r_b;
        o_stat.a_zero       = r_a == '0;
        o_stat.b_zero       = r_b == '0;
        o_stat.guard_over   = r_k > KW'(MAX_DEPTH);
        o_stat.hash_done    = hash_done;
        o_stat.e_valid      = e_vld;
        o_stat.e_match      = (e_par == r_a) && (e_tail == t_val);
        o_stat.probe_last   = r_i == EW'(EDGE_SLOTS - 1);
        o_stat.deep         = DXW'(n_dep) >= DXW'(MAX_DEPTH);
        o_stat.full         = r_cnt >= CNW'(NODE_SLOTS);
        o_stat.have_free    = r_free;
        o_stat.out_free     = out_free;
        o_stat.mat_last     = (r_k + KW'(1)) == KW'(r_in.first_depth);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNW'(1);
            r_clr <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + EW'(1);
            end
            if (i_cmd.alloc) begin
                r_cnt <= r_cnt + CNW'(1);
            end
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_in) begin
            r_in <= i_in;
            r_a  <= HW'(i_in.first_handle);
            r_b  <= HW'(i_in.second_handle);
            r_k  <= '0;
        end
        if (i_cmd.a_par) begin
            r_a <= n_par;
        end
        if (i_cmd.b_par) begin
            r_b <= n_par;
        end
        if (i_cmd.k_inc) begin
            r_k <= r_k + KW'(1);
        end
        if (i_cmd.tgt_d1) begin
            r_tgt <= DXW'(r_in.first_depth);
        end else if (i_cmd.tgt_d2) begin
            r_tgt <= DXW'(r_in.second_depth);
        end else if (i_cmd.tgt_rd) begin
            r_tgt <= DXW'(n_dep);
        end
        if (i_cmd.probe_init) begin
            r_s <= hash_slot;
            r_i <= '0;
        end else if (i_cmd.probe_next) begin
            r_s <= (r_s == EW'(EDGE_SLOTS - 1)) ? '0 : r_s + EW'(1);
            r_i <= r_i + EW'(1);
        end
        if (i_cmd.set_free) begin
            r_free <= i_cmd.free_val;
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
endmodule

// ----- src/pit_ctrl.sv -----
// Controller state machine: sequences intern probes, parent walks and
// materialize output. Drives the datapath through t_cmd; depends on pit_pkg.
module pit_ctrl
    import pit_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_stall
);
    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_P_EMIT, S_BDEP, S_CLIMB, S_EMIT_A,
        S_EMIT_ST, S_CMP, S_UP_A, S_UP_B, S_MAT, S_HASH, S_PROBE_RD,
        S_PROBE_CHK, S_EMIT_EDGE, S_DEC_RD, S_DEC
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_st, n_st;
    logic       r_flag, n_flag;
    logic       r_onb, n_onb;
    t_cmd       cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_st    = r_st;
        n_flag  = r_flag;
        n_onb   = r_onb;
        cmd.st   = r_st;
        cmd.flag = r_flag;
        case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.lat_in = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_st   = ST_OK;
                n_flag = 1'b0;
                n_onb  = 1'b0;
                case (i_stat.op)
                    OP_INTERN: begin
                        if (i_stat.bad1) begin
                            n_st = ST_BAD;
                            n_state = S_EMIT_ST;
                        end else begin
                            cmd.hash_start = 1'b1;
                            n_state = S_HASH;
                        end
                    end
                    OP_PARENT: begin
                        if (i_stat.bad1) begin
                            n_st = ST_BAD;
                            n_state = S_EMIT_ST;
                        end else begin
                            cmd.nre = 1'b1;
                            cmd.nrd = RD_A;
                            n_state = S_P_EMIT;
                        end
                    end
                    OP_ANCESTOR: begin
                        if (i_stat.bad1) begin
                            n_st = ST_BAD;
                            n_state = S_EMIT_ST;
                        end else begin
                            cmd.tgt_d1 = 1'b1;
                            cmd.nre = 1'b1;
                            cmd.nrd = RD_A;
                            n_state = S_CLIMB;
                        end
                    end
                    OP_HAS: begin
                        if (i_stat.bad1 || i_stat.bad2) begin
                            n_st = ST_BAD;
                            n_state = S_EMIT_ST;
                        end else if (i_stat.d2_gt_d1) begin
                            n_state = S_EMIT_ST;
                        end else begin
                            cmd.tgt_d2 = 1'b1;
                            cmd.nre = 1'b1;
                            cmd.nrd = RD_A;
                            n_state = S_CLIMB;
                        end
                    end
                    OP_SHARES: begin
                        if (i_stat.bad1 || i_stat.bad2) begin
                            n_st = ST_BAD;
                            n_state = S_EMIT_ST;
                        end else if (i_stat.a_zero || i_stat.b_zero) begin
                            n_state = S_EMIT_ST;
                        end else begin
                            cmd.nre = 1'b1;
                            cmd.nrd = RD_B;
                            n_state = S_BDEP;
                        end
                    end
                    OP_MAT: begin
                        if (i_stat.bad1) begin
                            n_st = ST_BAD;
                            n_state = S_EMIT_ST;
                        end else if (i_stat.d1_over) begin
                            n_st = ST_DEEP;
                            n_state = S_EMIT_ST;
                        end else if (i_stat.d1_zero) begin
                            n_state = S_IDLE;
                        end else begin
                            cmd.nre = 1'b1;
                            cmd.nrd = RD_A;
                            n_state = S_MAT;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_P_EMIT: begin
                if (i_stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.emit_sel = E_PARENT;
                    n_state = S_IDLE;
                end
            end
            S_BDEP: begin
                // left side climbs to the depth of the right side first
                cmd.tgt_rd = 1'b1;
                cmd.nre = 1'b1;
                cmd.nrd = RD_A;
                n_state = S_CLIMB;
            end
            S_CLIMB: begin
                if (i_stat.depth_gt_tgt) begin
                    cmd.nre = 1'b1;
                    cmd.nrd = RD_PAR;
                    cmd.a_par = !r_onb;
                    cmd.b_par = r_onb;
                end else begin
                    case (i_stat.op)
                        OP_ANCESTOR: n_state = S_EMIT_A;
                        OP_HAS: begin
                            n_flag = i_stat.a_eq_b;
                            n_state = S_EMIT_ST;
                        end
                        default: begin
                            if (!r_onb) begin
                                cmd.tgt_rd = 1'b1;
                                cmd.nre = 1'b1;
                                cmd.nrd = RD_B;
                                n_onb = 1'b1;
                            end else begin
                                n_state = S_CMP;
                            end
                        end
                    endcase
                end
            end
            S_EMIT_A: begin
                if (i_stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.emit_sel = E_A;
                    n_state = S_IDLE;
                end
            end
            S_EMIT_ST: begin
                if (i_stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.emit_sel = E_STATUS;
                    n_state = S_IDLE;
                end
            end
            S_CMP: begin
                if (i_stat.a_eq_b) begin
                    n_flag = !i_stat.a_zero;
                    n_state = S_EMIT_ST;
                end else if (i_stat.a_zero || i_stat.b_zero || i_stat.guard_over) begin
                    n_flag = 1'b0;
                    n_state = S_EMIT_ST;
                end else begin
                    cmd.nre = 1'b1;
                    cmd.nrd = RD_A;
                    n_state = S_UP_A;
                end
            end
            S_UP_A: begin
                cmd.a_par = 1'b1;
                cmd.nre = 1'b1;
                cmd.nrd = RD_B;
                n_state = S_UP_B;
            end
            S_UP_B: begin
                cmd.b_par = 1'b1;
                cmd.k_inc = 1'b1;
                n_state = S_CMP;
            end
            S_MAT: begin
                if (i_stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.emit_sel = E_MAT;
                    if (i_stat.mat_last) begin
                        n_state = S_IDLE;
                    end else begin
                        cmd.nre = 1'b1;
                        cmd.nrd = RD_PAR;
                        cmd.a_par = 1'b1;
                        cmd.k_inc = 1'b1;
                    end
                end
            end
            S_HASH: begin
                if (i_stat.hash_done) begin
                    cmd.probe_init = 1'b1;
                    n_state = S_PROBE_RD;
                end
            end
            S_PROBE_RD: begin
                cmd.erd = 1'b1;
                n_state = S_PROBE_CHK;
            end
            S_PROBE_CHK: begin
                if (!i_stat.e_valid) begin
                    cmd.set_free = 1'b1;
                    cmd.free_val = 1'b1;
                    n_state = S_DEC_RD;
                end else if (i_stat.e_match) begin
                    n_state = S_EMIT_EDGE;
                end else if (i_stat.probe_last) begin
                    cmd.set_free = 1'b1;
                    cmd.free_val = 1'b0;
                    n_state = S_DEC_RD;
                end else begin
                    cmd.probe_next = 1'b1;
                    n_state = S_PROBE_RD;
                end
            end
            S_EMIT_EDGE: begin
                if (i_stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.emit_sel = E_EDGE;
                    n_state = S_IDLE;
                end
            end
            S_DEC_RD: begin
                cmd.nre = 1'b1;
                cmd.nrd = RD_A;
                n_state = S_DEC;
            end
            S_DEC: begin
                if (i_stat.deep) begin
                    n_st = ST_DEEP;
                    n_state = S_EMIT_ST;
                end else if (i_stat.full || !i_stat.have_free) begin
                    n_st = ST_FULL;
                    n_state = S_EMIT_ST;
                end else if (i_stat.out_free) begin
                    cmd.alloc = 1'b1;
                    cmd.emit = 1'b1;
                    cmd.emit_sel = E_NEW;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_st    <= ST_OK;
            r_flag  <= 1'b0;
            r_onb   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
            r_flag  <= n_flag;
            r_onb   <= n_onb;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_stall = r_state != S_IDLE;
endmodule

// ----- src/path_interning_trie.sv -----
// Top level of the path interning trie: controller plus datapath.
// Depends on pit_pkg, pit_ctrl and pit_datapath.
//
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//
// One transaction at a time. Ancestor and has prefix climb parent steps;
// shares prefix climbs, then walks common steps. Materialize emits one
// result per cycle while the output is not stalled. Intern hashes, then
// probes the edge table and allocates or refuses a node (hash uses one
// shared multiplier over 4 steps; a non power of two table adds a digit-wise
// modulo). After reset a clearing pass over the edge table runs before the
// first input. A stalled output holds the controller in its emit state.
module path_interning_trie
    import pit_pkg::*;
#(
    parameter int NODE_SLOTS = NODE_SLOTS_DEF,
    parameter int EDGE_SLOTS = EDGE_SLOTS_DEF,
    parameter int ID_WIDTH   = ID_WIDTH_DEF,
    parameter int MAX_DEPTH  = MAX_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);
    t_cmd  cmd;
    t_stat stat;

    pit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    pit_datapath #(
        .NODE_SLOTS (NODE_SLOTS),
        .EDGE_SLOTS (EDGE_SLOTS),
        .ID_WIDTH   (ID_WIDTH),
        .MAX_DEPTH  (MAX_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in_data),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );
endmodule

// ----- src/pit_checker.sv -----
// Port-level checks for path_interning_trie, bound to the top level.
// Depends on pit_pkg.
module pit_checker
    import pit_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output transaction changed");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK) |->
            o_out_data.last && (o_out_data.result_handle == 10'd0) && !o_out_data.flag)
        else $error("error result not a lone zeroed transaction");

    a_flag_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.flag |->
            (o_out_data.status == ST_OK) && (o_out_data.result_handle == 10'd0)
            && (o_out_data.out_tail == 32'd0) && o_out_data.last)
        else $error("flag set on a non-query result");

    a_pos_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.position != 5'd0) |->
            (o_out_data.status == ST_OK) && !o_out_data.last)
        else $error("nonzero position on a final or error result");
endmodule

bind path_interning_trie pit_checker u_pit_checker (.*);

// ----- tb/sv/path_interning_trie_test.sv -----
// Self-checking testbench for path_interning_trie: random and directed trie operations,
// checked against an in-bench trie model. Depends on pit_pkg and the RTL under src.
`timescale 1ns / 100ps

module path_interning_trie_test;
    import pit_pkg::*;

    localparam int NODES   = 1024;
    localparam int EDGES   = 2048;
    localparam int DEPTH_MAX = 32;
    localparam int WATCHDOG_LIMIT = 20000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    path_interning_trie i_dut (.*);

    always #4 i_clk = ~i_clk;

    // trie model state
    logic [9:0]  tr_parent [NODES];
    logic [31:0] tr_tail [NODES];
    int unsigned tr_depth [NODES];
    int unsigned tr_count;
    bit          slot_used [EDGES];
    logic [9:0]  slot_parent [EDGES];
    logic [31:0] slot_tail [EDGES];
    logic [9:0]  slot_handle [EDGES];

    t_in_item  pending_ops [$];
    t_out_item expected_results [$];
    int        error_count = 0;
    int        send_idle_pct = 37;
    int        recv_idle_pct = 70;
    bit        hold_out = 1'b0;
    bit        in_taken = 1'b0;
    int        quiet_cycles = 0;

    function automatic t_out_item make_result(int h, int f, logic [31:0] t,
                                              int pos, int lst, logic [1:0] st);
        t_out_item r;
        r.result_handle = 10'(h);
        r.flag = 1'(f);
        r.out_tail = t;
        r.position = 5'(pos);
        r.last = 1'(lst);
        r.status = st;
        return r;
    endfunction

    function automatic void queue_result(t_out_item r);
        expected_results = {expected_results, r};
    endfunction

    function automatic logic [10:0] edge_hash(logic [9:0] p, logic [31:0] t);
        logic [63:0] h;
        h = {54'd0, p} * HASH_K1;
        h ^= {32'd0, t} * HASH_K2;
        h ^= h >> 29;
        return h[10:0];
    endfunction

    function automatic logic [9:0] climb(logic [9:0] h, int unsigned d);
        int unsigned guard = 0;
        while (tr_depth[h] > d && guard <= DEPTH_MAX) begin
            h = tr_parent[h];
            guard++;
        end
        return h;
    endfunction

    function automatic logic common_root_free(logic [9:0] a, logic [9:0] b);
        int unsigned guard = 0;
        if (a == 0 || b == 0) return 1'b0;
        a = climb(a, tr_depth[b]);
        b = climb(b, tr_depth[a]);
        while (a != b && guard <= DEPTH_MAX) begin
            if (a == 0 || b == 0) return 1'b0;
            a = tr_parent[a];
            b = tr_parent[b];
            guard++;
        end
        return (a == b && a != 0);
    endfunction

    task automatic predict_trie(t_in_item it);
        logic [9:0]  h1, h2, h;
        logic [10:0] s;
        int unsigned d1, d2;
        bit          have_free, found;
        h1 = it.first_handle;
        h2 = it.second_handle;
        d1 = it.first_depth;
        d2 = it.second_depth;
        case (it.operation)
            OP_INTERN: begin
                if (h1 >= tr_count) begin
                    queue_result(make_result(0, 0, 0, 0, 1, ST_BAD));
                end else begin
                    s = edge_hash(h1, it.tail_value);
                    have_free = 0;
                    found = 0;
                    for (int i = 0; i < EDGES; i++) begin
                        if (!slot_used[s]) begin
                            have_free = 1;
                            break;
                        end
                        if (slot_parent[s] == h1 && slot_tail[s] == it.tail_value) begin
                            found = 1;
                            break;
                        end
                        s = s + 1;
                    end
                    if (found)
                        queue_result(make_result(slot_handle[s], 0, 0, 0, 1, ST_OK));
                    else if (tr_depth[h1] + 1 > DEPTH_MAX)
                        queue_result(make_result(0, 0, 0, 0, 1, ST_DEEP));
                    else if (tr_count >= NODES || !have_free)
                        queue_result(make_result(0, 0, 0, 0, 1, ST_FULL));
                    else begin
                        h = tr_count[9:0];
                        tr_parent[h] = h1;
                        tr_tail[h] = it.tail_value;
                        tr_depth[h] = tr_depth[h1] + 1;
                        tr_count++;
                        slot_used[s] = 1;
                        slot_parent[s] = h1;
                        slot_tail[s] = it.tail_value;
                        slot_handle[s] = h;
                        queue_result(make_result(h, 0, 0, 0, 1, ST_OK));
                    end
                end
            end
            OP_PARENT, OP_ANCESTOR: begin
                if (h1 >= tr_count)
                    queue_result(make_result(0, 0, 0, 0, 1, ST_BAD));
                else if (it.operation == OP_PARENT)
                    queue_result(make_result(tr_parent[h1], 0, 0, 0, 1, ST_OK));
                else
                    queue_result(make_result(climb(h1, d1), 0, 0, 0, 1, ST_OK));
            end
            OP_HAS, OP_SHARES: begin
                if (h1 >= tr_count || h2 >= tr_count)
                    queue_result(make_result(0, 0, 0, 0, 1, ST_BAD));
                else if (it.operation == OP_SHARES)
                    queue_result(make_result(0, common_root_free(h1, h2),
                                             0, 0, 1, ST_OK));
                else if (d2 > d1)
                    queue_result(make_result(0, 0, 0, 0, 1, ST_OK));
                else
                    queue_result(make_result(0, climb(h1, d2) == h2,
                                             0, 0, 1, ST_OK));
            end
            OP_MAT: begin
                if (h1 >= tr_count)
                    queue_result(make_result(0, 0, 0, 0, 1, ST_BAD));
                else if (d1 > DEPTH_MAX)
                    queue_result(make_result(0, 0, 0, 0, 1, ST_DEEP));
                else begin
                    h = h1;
                    for (int k = 0; k < d1; k++) begin
                        queue_result(make_result(h, 0, tr_tail[h],
                            5'(d1 - 1 - k), k + 1 == d1, ST_OK));
                        h = tr_parent[h];
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_data <= pending_ops.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= hold_out || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor: prediction on input acceptance, checking on output acceptance
    always @(posedge i_clk) begin
        t_out_item want;
        bit        busy;
        if (i_rst_n) begin
            busy = 1'b0;
            if (i_in_valid && !o_in_stall) begin
                predict_trie(i_in_data);
                busy = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                busy = 1'b1;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transaction", o_out_data, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_data.result_handle != want.result_handle)
                        report_mismatch("result_handle", o_out_data.result_handle,
                                        want.result_handle);
                    if (o_out_data.flag != want.flag)
                        report_mismatch("flag", o_out_data.flag, want.flag);
                    if (o_out_data.out_tail != want.out_tail)
                        report_mismatch("out_tail", o_out_data.out_tail, want.out_tail);
                    if (o_out_data.position != want.position)
                        report_mismatch("position", o_out_data.position, want.position);
                    if (o_out_data.last != want.last)
                        report_mismatch("last", o_out_data.last, want.last);
                    if (o_out_data.status != want.status)
                        report_mismatch("status", o_out_data.status, want.status);
                end
            end
            quiet_cycles <= busy ? 0 : quiet_cycles + 1;
            in_taken <= i_in_valid && !o_in_stall;
        end
    end

    // watchdog; the initial edge-table clear counts as quiet time too
    always @(posedge i_clk) begin
        if (quiet_cycles > WATCHDOG_LIMIT + EDGES) begin
            $display("path_interning_trie_test: errors");
            $finish;
        end
    end

    logic [9:0] known_nodes [$];

    function automatic logic [9:0] pick_node();
        if (known_nodes.size() == 0 || $urandom_range(9) == 0) return 10'($urandom_range(3));
        return known_nodes[$urandom_range(known_nodes.size() - 1)];
    endfunction

    function automatic t_in_item make_op(logic [2:0] op, int h1, int h2,
                                         logic [31:0] t, int d1, int d2);
        t_in_item it;
        it.operation = op;
        it.first_handle = 10'(h1);
        it.second_handle = 10'(h2);
        it.tail_value = t;
        it.first_depth = 6'(d1);
        it.second_depth = 6'(d2);
        return it;
    endfunction

    function automatic void queue_op(t_in_item it);
        pending_ops = {pending_ops, it};
    endfunction

    task automatic wait_drained();
        while (pending_ops.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic [2:0] op;
        tr_count = 1;
        tr_parent[0] = '0;
        tr_tail[0] = '0;
        tr_depth[0] = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: build a chain and a sibling, hit each special case
        queue_op(make_op(OP_INTERN, 0, 0, 32'hFFFF_FFFF, 0, 0));
        queue_op(make_op(OP_INTERN, 0, 0, 32'hFFFF_FFFF, 0, 0));
        queue_op(make_op(OP_INTERN, 1, 0, 32'h0, 0, 0));
        queue_op(make_op(OP_INTERN, 0, 0, 32'h1234_5678, 0, 0));
        queue_op(make_op(OP_INTERN, 10'h3FF, 0, 32'h1, 0, 0));
        for (int i = 0; i < 31; i++)
            queue_op(make_op(OP_INTERN, i == 0 ? 2 : 3 + i, 0, i, 0, 0));
        queue_op(make_op(OP_INTERN, 32, 0, 32'hAAAA_5555, 0, 0));
        queue_op(make_op(OP_PARENT, 2, 0, 0, 0, 0));
        queue_op(make_op(OP_PARENT, 0, 0, 0, 0, 0));
        queue_op(make_op(OP_PARENT, 10'h3FF, 0, 0, 0, 0));
        queue_op(make_op(OP_ANCESTOR, 33, 0, 0, 3, 0));
        queue_op(make_op(OP_ANCESTOR, 33, 0, 0, 6'h3F, 0));
        queue_op(make_op(OP_HAS, 33, 1, 0, 32, 1));
        queue_op(make_op(OP_HAS, 33, 0, 0, 32, 0));
        queue_op(make_op(OP_HAS, 33, 3, 0, 32, 0));
        queue_op(make_op(OP_HAS, 2, 1, 0, 1, 6'h3F));
        queue_op(make_op(OP_HAS, 2, 10'h3FF, 0, 1, 1));
        queue_op(make_op(OP_SHARES, 33, 2, 0, 0, 0));
        queue_op(make_op(OP_SHARES, 33, 3, 0, 0, 0));
        queue_op(make_op(OP_SHARES, 0, 2, 0, 0, 0));
        queue_op(make_op(OP_SHARES, 2, 10'h3FF, 0, 0, 0));
        queue_op(make_op(OP_MAT, 33, 0, 0, 32, 0));
        queue_op(make_op(OP_MAT, 2, 0, 0, 4, 0));
        queue_op(make_op(OP_MAT, 2, 0, 0, 0, 0));
        queue_op(make_op(OP_MAT, 2, 0, 0, 6'h3F, 0));
        queue_op(make_op(OP_MAT, 10'h3FF, 0, 0, 1, 0));
        queue_op(make_op(3'd6, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF, 6'h3F, 6'h3F));
        queue_op(make_op(3'd7, 0, 0, 0, 0, 0));
        for (int i = 1; i <= 34; i++) known_nodes = {known_nodes, 10'(i)};

        // long receiver hold while the sender keeps offering, after the clear
        while (o_in_stall) @(posedge i_clk);
        hold_out = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_out = 1'b0;
        wait_drained();
        repeat (200) @(posedge i_clk);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 37 : phase == 1 ? 70 : 0;
            recv_idle_pct = phase == 0 ? 70 : phase == 1 ? 37 : 0;
            for (int n = 0; n < 37; n++) begin
                op = $urandom_range(9) < 4 ? OP_INTERN : 3'($urandom_range(7));
                queue_op(make_op(op, pick_node(), pick_node(),
                    $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(3)),
                    $urandom_range(op == OP_MAT ? 12 : 63),
                    $urandom_range(40)));
                if (op == OP_INTERN)
                    known_nodes = {known_nodes, 10'(known_nodes.size() + 1)};
            end
            // sender waits for every expected result before the next phase
            wait_drained();
        end
        repeat (200) @(posedge i_clk);
        if (error_count == 0)
            $display("path_interning_trie_test: clean");
        else
            $display("path_interning_trie_test: errors");
        $finish;
    end

endmodule

// ----- path_interning_trie.f -----
src/pit_pkg.sv
src/pit_ram.sv
src/pit_hash.sv
src/pit_datapath.sv
src/pit_ctrl.sv
src/path_interning_trie.sv
src/pit_checker.sv
tb/sv/path_interning_trie_test.sv
